>>> rtl/drc_pkg.sv
// Shared constants, types and the square-root table of the dynamic range compressor.
`default_nettype none

package drc_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 16;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;

	localparam int DIV_NUM_W = 36;
	localparam int DIV_DEN_W = 26;
	localparam int GR_W      = 16;

	localparam int LEVEL_W        = 17;
	localparam int LEVEL_FLOOR    = 40960;
	localparam int DB_TO_LOG2_Q16 = 394567;
	localparam int LOG2_PER_DB    = 10885;

	localparam int THR_MIN   = -15360;
	localparam int THR_MAX   = -1280;
	localparam int RATIO_MIN = 307;
	localparam int RATIO_MAX = 1536;
	localparam int KNEE_MAX  = 3072;
	localparam int MKUP_MIN  = -6144;
	localparam int MKUP_MAX  = 6144;

	localparam int ROOT_N = 16;
	localparam int ROOT_W = 32;

	typedef enum logic [2:0] {
		REG_ENABLE    = 3'd0,
		REG_THRESHOLD = 3'd1,
		REG_RATIO     = 3'd2,
		REG_KNEE      = 3'd3,
		REG_AUTO_MKUP = 3'd4,
		REG_MKUP      = 3'd5,
		REG_ATTACK    = 3'd6,
		REG_RELEASE   = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ_MUL,
		ST_SQ_UPD,
		ST_LV_MUL,
		ST_LV_UPD,
		ST_GC,
		ST_HD_DIV,
		ST_SF_C,
		ST_SF_WR,
		ST_SF_DIV,
		ST_DIV_WAIT,
		ST_EXP_MUL,
		ST_EXP_SPLIT,
		ST_EXP_STEP,
		ST_EXP_UPD,
		ST_EXP_SHIFT,
		ST_SM_MUL,
		ST_SM_UPD,
		ST_OUT_MUL,
		ST_OUT_RND,
		ST_FIN
	} state_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Entry k-1 holds 2^(2^-k) in Q30, each the floor square root of the one before.
	function automatic logic [ROOT_N*ROOT_W-1:0] build_roots();
		logic [63:0] cur;
		logic [ROOT_N*ROOT_W-1:0] tab;
		cur = 64'd1 << 31;
		tab = '0;
		for (int k = 0; k < ROOT_N; k++) begin
			cur = isqrt64(cur << 30);
			tab[k*ROOT_W +: ROOT_W] = cur[ROOT_W-1:0];
		end
		return tab;
	endfunction

	localparam logic [ROOT_N*ROOT_W-1:0] ROOT_TAB = build_roots();

endpackage

`default_nettype wire

>>> rtl/dynamic_range_compressor.sv
// Top level of the feed-forward soft-knee dynamic range compressor.
//
//  Channel   Direction  Handshake             Beat payload
//  in        sink       in_valid / in_stall   in_sample
//  out       source     out_valid / out_stall out_sample, applied_gain
//  apb       slave      psel, penable, pready paddr, pwdata, prdata
//
// A compressed sample runs through steps set by the data: normalising the magnitude, the log
// squarings, the gain divide in the divider and the exponent chain, with every product taken
// from one shared 32 by 32 multiplier.
// A disabled sample skips the datapath; the input stalls whenever the sequencer is busy.
// Reset returns the envelope to unity and the registers to their documented values.
// A finished beat waits in the output register while the next sample is worked on.
`default_nettype none

module dynamic_range_compressor #(
	parameter int SAMPLE_BITS    = drc_pkg::SAMPLE_BITS,
	parameter int GAIN_FRAC_BITS = drc_pkg::GAIN_FRAC_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]   in_sample,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [SAMPLE_BITS-1:0]        out_sample,
	output logic [GAIN_FRAC_BITS+3:0]            applied_gain,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [drc_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [drc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [drc_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	localparam int SB      = SAMPLE_BITS;
	localparam int GW      = GAIN_FRAC_BITS + 4;
	localparam int PW      = $clog2(SAMPLE_BITS);
	localparam int MW      = drc_pkg::MUL_W;
	localparam int PRW     = drc_pkg::PROD_W;
	localparam int NW      = drc_pkg::DIV_NUM_W;
	localparam int DW      = drc_pkg::DIV_DEN_W;
	localparam int LW      = drc_pkg::LEVEL_W;
	localparam int SH_BASE = 30 - GAIN_FRAC_BITS;

	localparam logic [GW-1:0]  UNITY = GW'(1) << GAIN_FRAC_BITS;
	localparam logic [GW-1:0]  MAXG  = {GW{1'b1}};
	localparam logic [PRW-1:0] SMAX  = (PRW'(1) << (SB - 1)) - PRW'(1);

	// Configuration registers.
	logic              en_q;
	logic signed [14:0] thr_q;
	logic [10:0]       ratio_q;
	logic [11:0]       knee_q;
	logic              auto_q;
	logic signed [13:0] mkup_q;
	logic [15:0]       att_q;
	logic [15:0]       rel_q;

	// Sequencer and datapath registers.
	drc_pkg::state_t   state_q, state_d;
	logic [SB-1:0]     mag_q;
	logic              neg_q;
	logic [SB-1:0]     norm_q;
	logic [PW-1:0]     p_q;
	logic [30:0]       x_q;
	logic [15:0]       lf_q;
	logic [3:0]        i_q;
	logic signed [LW-1:0] level_q;
	logic [NW-1:0]     num_q;
	logic [drc_pkg::GR_W-1:0] q_q;
	logic              dbneg_q;
	logic signed [4:0] n_q;
	logic [23:0]       ef_q;
	logic [30:0]       acc_q;
	logic [GW-1:0]     target_q;
	logic [GW-1:0]     env_q;
	logic [PRW-1:0]    prod_q;
	logic [SB-1:0]     res_sample_q;
	logic [GW-1:0]     res_gain_q;
	logic              out_valid_q;
	logic [SB-1:0]     out_sample_q;
	logic [GW-1:0]     out_gain_q;

	logic [MW-1:0] mul_a, mul_b;
	logic          div_start;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic          div_done;
	logic [NW-1:0] div_quot;

	logic in_fire, out_fire, cfg_wr;
	logic [SB-1:0] in_mag;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;
	assign in_stall = (state_q != drc_pkg::ST_IDLE);
	assign in_mag   = in_sample[SB-1] ? SB'(~in_sample + 1'b1) : in_sample;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	// Register clamps and the gain computer's decision.
	logic signed [14:0] t_c;
	logic [10:0]        r_c, c_c;
	logic [11:0]        w_c;
	logic signed [14:0] mk_c;
	logic signed [16:0] mk_auto;
	logic signed [17:0] d_c;
	logic signed [18:0] twod, w_s;
	logic [12:0]        s_c;
	logic               hard, zero_gr;

	always_comb begin
		t_c = thr_q;
		if (thr_q < 15'(drc_pkg::THR_MIN)) t_c = 15'(drc_pkg::THR_MIN);
		if (thr_q > 15'(drc_pkg::THR_MAX)) t_c = 15'(drc_pkg::THR_MAX);
		r_c = ratio_q;
		if (ratio_q < 11'(drc_pkg::RATIO_MIN)) r_c = 11'(drc_pkg::RATIO_MIN);
		if (ratio_q > 11'(drc_pkg::RATIO_MAX)) r_c = 11'(drc_pkg::RATIO_MAX);
		w_c = (knee_q > 12'(drc_pkg::KNEE_MAX)) ? 12'(drc_pkg::KNEE_MAX) : knee_q;
		c_c = r_c - 11'd256;
		// Automatic makeup is a quarter of the threshold's depth, rounded.
		mk_auto = (17'sd2 - 17'(t_c)) >>> 2;
		if (auto_q) begin
			mk_c = 15'(mk_auto);
		end else begin
			mk_c = 15'(mkup_q);
			if (mkup_q < 14'(drc_pkg::MKUP_MIN)) mk_c = 15'(drc_pkg::MKUP_MIN);
			if (mkup_q > 14'(drc_pkg::MKUP_MAX)) mk_c = 15'(drc_pkg::MKUP_MAX);
		end
		d_c  = 18'(level_q) - 18'(t_c);
		twod = {d_c, 1'b0};
		w_s  = $signed({7'b0, w_c});
		s_c  = 13'(twod + w_s);
		hard = (w_c == 12'd0) || (twod >= w_s);
		// Below threshold on a hard knee, or below the knee's lower edge, no reduction.
		zero_gr = hard ? (d_c <= 18'sd0) : (twod <= -w_s);
	end

	// Decibel sum for the exponent, and its magnitude.
	logic signed [16:0] db_c;
	logic [15:0]        db_abs;
	assign db_c   = 17'(mk_c) - $signed({1'b0, q_q});
	assign db_abs = db_c[16] ? 16'(-db_c) : db_c[15:0];

	// Exponent split: floor of the log2 value and its fraction.
	logic signed [28:0] e_c;
	assign e_c = dbneg_q ? -$signed({1'b0, prod_q[27:0]}) : $signed({1'b0, prod_q[27:0]});

	// Log step, level and exponent helpers.
	logic [31:0] sq_y;
	logic [20:0] lv_n;
	logic [16:0] lv_mag;
	logic        ef_bit;
	logic [drc_pkg::ROOT_W-1:0] root_c;
	logic signed [7:0] sh;
	logic [32:0] rnd;
	logic [GW-1:0] tgt_c;

	assign sq_y   = prod_q[61:30];
	assign lv_n   = ((21'(SB - 1) - 21'(p_q)) << 16) - 21'(lf_q);
	assign lv_mag = 17'((prod_q + (PRW'(1) << 23)) >> 24);
	assign ef_bit = ef_q[5'd23 - 5'(i_q)];
	assign root_c = drc_pkg::ROOT_TAB[{i_q, 5'b0} +: drc_pkg::ROOT_W];
	assign sh     = 8'(SH_BASE) - 8'(n_q);

	always_comb begin
		if (sh >= 8'sd32) begin
			rnd = '0;
		end else if (sh <= 8'sd0) begin
			rnd = 33'(acc_q);
		end else begin
			rnd = (33'(acc_q) + (33'd1 << (sh - 8'sd1))) >> sh;
		end
		tgt_c = (rnd > 33'(MAXG)) ? MAXG : GW'(rnd);
	end

	// Envelope smoothing: attack while the target sits below the envelope.
	logic          below;
	logic [GW-1:0] diff_c, step_c;
	logic [16:0]   coef_c;
	assign below  = target_q < env_q;
	assign diff_c = below ? (env_q - target_q) : (target_q - env_q);
	assign coef_c = 17'h10000 - 17'(below ? att_q : rel_q);
	assign step_c = GW'((prod_q + PRW'(32768)) >> 16);

	// Output rounding and saturation.
	logic [PRW-1:0] pr_c;
	logic [SB-1:0]  ysat;
	assign pr_c = (prod_q + (PRW'(1) << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
	always_comb begin
		if (neg_q) begin
			ysat = (pr_c > SMAX + PRW'(1)) ? {1'b1, {(SB-1){1'b0}}} : SB'(-pr_c);
		end else begin
			ysat = (pr_c > SMAX) ? SMAX[SB-1:0] : pr_c[SB-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drc_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (!en_q) state_d = drc_pkg::ST_FIN;
					else if (in_mag == '0) state_d = drc_pkg::ST_GC;
					else state_d = drc_pkg::ST_NORM;
				end
			end
			drc_pkg::ST_NORM:      if (norm_q[SB-1]) state_d = drc_pkg::ST_SQ_MUL;
			drc_pkg::ST_SQ_MUL:    state_d = drc_pkg::ST_SQ_UPD;
			drc_pkg::ST_SQ_UPD:    state_d = (i_q == 4'd15) ? drc_pkg::ST_LV_MUL : drc_pkg::ST_SQ_MUL;
			drc_pkg::ST_LV_MUL:    state_d = drc_pkg::ST_LV_UPD;
			drc_pkg::ST_LV_UPD:    state_d = drc_pkg::ST_GC;
			drc_pkg::ST_GC: begin
				if (zero_gr) state_d = drc_pkg::ST_EXP_MUL;
				else if (hard) state_d = drc_pkg::ST_HD_DIV;
				else state_d = drc_pkg::ST_SF_C;
			end
			drc_pkg::ST_HD_DIV:    state_d = drc_pkg::ST_DIV_WAIT;
			drc_pkg::ST_SF_C:      state_d = drc_pkg::ST_SF_WR;
			drc_pkg::ST_SF_WR:     state_d = drc_pkg::ST_SF_DIV;
			drc_pkg::ST_SF_DIV:    state_d = drc_pkg::ST_DIV_WAIT;
			drc_pkg::ST_DIV_WAIT:  if (div_done) state_d = drc_pkg::ST_EXP_MUL;
			drc_pkg::ST_EXP_MUL:   state_d = drc_pkg::ST_EXP_SPLIT;
			drc_pkg::ST_EXP_SPLIT: begin
				state_d = ($signed(e_c[28:24]) >= 5'sd4) ? drc_pkg::ST_SM_MUL
					: drc_pkg::ST_EXP_STEP;
			end
			drc_pkg::ST_EXP_STEP: begin
				if (ef_bit) state_d = drc_pkg::ST_EXP_UPD;
				else if (i_q == 4'd15) state_d = drc_pkg::ST_EXP_SHIFT;
			end
			drc_pkg::ST_EXP_UPD: begin
				state_d = (i_q == 4'd15) ? drc_pkg::ST_EXP_SHIFT : drc_pkg::ST_EXP_STEP;
			end
			drc_pkg::ST_EXP_SHIFT: state_d = drc_pkg::ST_SM_MUL;
			drc_pkg::ST_SM_MUL:    state_d = drc_pkg::ST_SM_UPD;
			drc_pkg::ST_SM_UPD:    state_d = drc_pkg::ST_OUT_MUL;
			drc_pkg::ST_OUT_MUL:   state_d = drc_pkg::ST_OUT_RND;
			drc_pkg::ST_OUT_RND:   state_d = drc_pkg::ST_FIN;
			drc_pkg::ST_FIN:       if (!out_valid_q || out_fire) state_d = drc_pkg::ST_IDLE;
			default:               state_d = drc_pkg::ST_IDLE;
		endcase
	end

	// Operands of the shared multiplier and divider control.
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			drc_pkg::ST_SQ_MUL: begin
				mul_a = MW'(x_q);
				mul_b = MW'(x_q);
			end
			drc_pkg::ST_LV_MUL: begin
				mul_a = MW'(lv_n);
				mul_b = MW'(drc_pkg::DB_TO_LOG2_Q16);
			end
			drc_pkg::ST_GC: begin
				mul_a = hard ? MW'(d_c[16:0]) : MW'(s_c);
				mul_b = hard ? MW'(c_c) : MW'(s_c);
			end
			drc_pkg::ST_HD_DIV: begin
				div_start = 1'b1;
				div_num   = NW'(prod_q) + NW'(r_c >> 1);
				div_den   = DW'(r_c);
			end
			drc_pkg::ST_SF_C: begin
				mul_a = prod_q[MW-1:0];
				mul_b = MW'(c_c);
			end
			drc_pkg::ST_SF_WR: begin
				mul_a = MW'(w_c);
				mul_b = MW'(r_c);
			end
			drc_pkg::ST_SF_DIV: begin
				div_start = 1'b1;
				div_num   = num_q + NW'(prod_q << 2);
				div_den   = DW'(prod_q << 3);
			end
			drc_pkg::ST_EXP_MUL: begin
				mul_a = MW'(db_abs);
				mul_b = MW'(drc_pkg::LOG2_PER_DB);
			end
			drc_pkg::ST_EXP_STEP: begin
				mul_a = MW'(acc_q);
				mul_b = root_c;
			end
			drc_pkg::ST_SM_MUL: begin
				mul_a = MW'(diff_c);
				mul_b = MW'(coef_c);
			end
			drc_pkg::ST_OUT_MUL: begin
				mul_a = MW'(mag_q);
				mul_b = MW'(env_q);
			end
			default: begin
			end
		endcase
	end

	drc_div #(
		.NUM_W (NW),
		.DEN_W (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Control state and registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			env_q       <= UNITY;
			en_q        <= 1'b0;
			thr_q       <= -15'sd5120;
			ratio_q     <= 11'd1024;
			knee_q      <= '0;
			auto_q      <= 1'b0;
			mkup_q      <= '0;
			att_q       <= '0;
			rel_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == drc_pkg::ST_FIN && (!out_valid_q || out_fire)) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == drc_pkg::ST_SM_UPD) begin
				env_q <= below ? env_q - step_c : env_q + step_c;
			end
			if (cfg_wr) begin
				unique case (drc_pkg::reg_idx_t'(paddr[4:2]))
					drc_pkg::REG_ENABLE:    en_q    <= pwdata[0];
					drc_pkg::REG_THRESHOLD: thr_q   <= pwdata[14:0];
					drc_pkg::REG_RATIO:     ratio_q <= pwdata[10:0];
					drc_pkg::REG_KNEE:      knee_q  <= pwdata[11:0];
					drc_pkg::REG_AUTO_MKUP: auto_q  <= pwdata[0];
					drc_pkg::REG_MKUP:      mkup_q  <= pwdata[13:0];
					drc_pkg::REG_ATTACK:    att_q   <= pwdata[15:0];
					drc_pkg::REG_RELEASE:   rel_q   <= pwdata[15:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= PRW'(mul_a) * PRW'(mul_b);
		unique case (state_q)
			drc_pkg::ST_IDLE: begin
				mag_q        <= in_mag;
				neg_q        <= in_sample[SB-1];
				norm_q       <= in_mag;
				p_q          <= PW'(SB - 1);
				level_q      <= -LW'(drc_pkg::LEVEL_FLOOR);
				res_sample_q <= in_sample;
				res_gain_q   <= UNITY;
			end
			drc_pkg::ST_NORM: begin
				if (norm_q[SB-1]) begin
					x_q  <= 31'((PRW'(norm_q) << 30) >> (SB - 1));
					lf_q <= '0;
					i_q  <= '0;
				end else begin
					norm_q <= norm_q << 1;
					p_q    <= p_q - PW'(1);
				end
			end
			drc_pkg::ST_SQ_UPD: begin
				x_q  <= sq_y[31] ? sq_y[31:1] : sq_y[30:0];
				lf_q <= {lf_q[14:0], sq_y[31]};
				i_q  <= i_q + 4'd1;
			end
			drc_pkg::ST_LV_UPD: begin
				level_q <= (lv_mag > 17'(drc_pkg::LEVEL_FLOOR)) ?
					-LW'(drc_pkg::LEVEL_FLOOR) : -$signed(lv_mag);
			end
			drc_pkg::ST_GC: begin
				q_q <= '0;
			end
			drc_pkg::ST_SF_WR: begin
				num_q <= NW'(prod_q);
			end
			drc_pkg::ST_DIV_WAIT: begin
				if (div_done) q_q <= div_quot[drc_pkg::GR_W-1:0];
			end
			drc_pkg::ST_EXP_MUL: begin
				dbneg_q <= db_c[16];
			end
			drc_pkg::ST_EXP_SPLIT: begin
				n_q      <= e_c[28:24];
				ef_q     <= e_c[23:0];
				acc_q    <= 31'h4000_0000;
				i_q      <= '0;
				target_q <= MAXG;
			end
			drc_pkg::ST_EXP_STEP: begin
				if (!ef_bit) i_q <= i_q + 4'd1;
			end
			drc_pkg::ST_EXP_UPD: begin
				acc_q <= prod_q[60:30];
				i_q   <= i_q + 4'd1;
			end
			drc_pkg::ST_EXP_SHIFT: begin
				target_q <= tgt_c;
			end
			drc_pkg::ST_OUT_RND: begin
				res_sample_q <= ysat;
				res_gain_q   <= env_q;
			end
			drc_pkg::ST_FIN: begin
				if (!out_valid_q || out_fire) begin
					out_sample_q <= res_sample_q;
					out_gain_q   <= res_gain_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		unique case (drc_pkg::reg_idx_t'(paddr[4:2]))
			drc_pkg::REG_ENABLE:    prdata = 32'(en_q);
			drc_pkg::REG_THRESHOLD: prdata = 32'(thr_q);
			drc_pkg::REG_RATIO:     prdata = 32'(ratio_q);
			drc_pkg::REG_KNEE:      prdata = 32'(knee_q);
			drc_pkg::REG_AUTO_MKUP: prdata = 32'(auto_q);
			drc_pkg::REG_MKUP:      prdata = 32'(mkup_q);
			drc_pkg::REG_ATTACK:    prdata = 32'(att_q);
			drc_pkg::REG_RELEASE:   prdata = 32'(rel_q);
			default:                prdata = '0;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign out_sample   = out_sample_q;
	assign applied_gain = out_gain_q;

`ifndef ASSERT_OFF
	// The divider only finishes while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == drc_pkg::ST_DIV_WAIT)
		else $error("divider finished outside its wait state");

	// The log operand stays normalised to [1, 2) through the squarings.
	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == drc_pkg::ST_SQ_MUL |-> x_q[30])
		else $error("log operand lost its normalisation");

	// The envelope moves only in the smoothing update.
	a_env_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(env_q) |-> $past(state_q) == drc_pkg::ST_SM_UPD)
		else $error("envelope changed outside the smoothing update");
`endif

endmodule

`default_nettype wire

>>> rtl/drc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module drc_div #(
	parameter int NUM_W = drc_pkg::DIV_NUM_W,
	parameter int DEN_W = drc_pkg::DIV_DEN_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, quot_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire
